// ----- sv/asc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// asc_pkg: shared types and constants
// Payload structs, class codes and sequencer states for the aliquot sum
// classifier.
// ----------------------------------------------------------------------------
package asc_pkg;

    localparam int VALUE_W = 16;
    localparam int SUM_W   = 19;
    localparam int TALLY_W = 32;

    localparam logic [SUM_W-1:0]   SUM_MAX     = 19'h3FFFF;
    localparam logic [SUM_W-1:0]   SUM_NEG_ONE = 19'h7FFFF;
    localparam logic [TALLY_W-1:0] TALLY_MAX   = 32'hFFFF_FFFF;

    typedef enum logic [1:0] {
        CLASS_DEFICIENT = 2'd0,
        CLASS_ABUNDANT  = 2'd1,
        CLASS_PERFECT   = 2'd2
    } num_class_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TEST,
        ST_DIV,
        ST_ADD,
        ST_DONE
    } asc_state_t;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic               restart;
    } asc_in_t;

    typedef struct packed {
        logic signed [SUM_W-1:0] divisor_sum;
        logic [1:0]              number_class;
        logic [TALLY_W-1:0]      deficient_count;
        logic [TALLY_W-1:0]      abundant_count;
        logic [TALLY_W-1:0]      perfect_count;
    } asc_out_t;

endpackage
`default_nettype wire

// ----- sv/asc_divider.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// asc_divider: radix-2 restoring divider
// Produces quotient and remainder one bit per cycle; results hold until the
// next start.
// ----------------------------------------------------------------------------
module asc_divider #(
    parameter int WIDTH = 16
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             start,
    input  wire logic [WIDTH-1:0] dividend,
    input  wire logic [WIDTH-1:0] divisor,
    output logic                  done,
    output logic [WIDTH-1:0]      quotient,
    output logic [WIDTH-1:0]      remainder
);

    localparam int CW = $clog2(WIDTH + 1);

    logic [WIDTH-1:0] rem_reg, rem_next;
    logic [WIDTH-1:0] quo_reg, quo_next;
    logic [WIDTH-1:0] dvs_reg, dvs_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [WIDTH:0]   rem_shift;
    logic [WIDTH:0]   diff;

    // One restoring step: shift in the next dividend bit and try a subtract
    always_comb begin
        rem_shift = {rem_reg, quo_reg[WIDTH-1]};
        diff      = rem_shift - {1'b0, dvs_reg};
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
            cnt_next  = CW'(WIDTH);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (!diff[WIDTH]) begin
                rem_next = diff[WIDTH-1:0];
                quo_next = {quo_reg[WIDTH-2:0], 1'b1};
            end else begin
                rem_next = rem_shift[WIDTH-1:0];
                quo_next = {quo_reg[WIDTH-2:0], 1'b0};
            end
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule
`default_nettype wire

// ----- sv/aliquot_sum_classifier.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Operation: one item at a time; each candidate divisor costs a test step, one pass of
//   the shared bit-serial divider and an add step.
// Reset: synchronous active-low aresetn clears the sequencer, the output
//   valid and the three tallies.
// ----------------------------------------------------------------------------
// aliquot_sum_classifier: proper divisor sum and class tallies
// Trial-divides by d while d*d <= n, adds each divisor pair, then classes
// the number as deficient, abundant or perfect and bumps saturating tallies.
// ----------------------------------------------------------------------------
module aliquot_sum_classifier #(
    parameter int VALUE_BITS = 16
) (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            s_valid,
    output logic                 s_ready,
    input  wire asc_pkg::asc_in_t  s_payload,
    output logic                 m_valid,
    input  wire logic            m_ready,
    output asc_pkg::asc_out_t    m_payload
);

    import asc_pkg::*;

    localparam int NW  = VALUE_BITS;
    localparam int HW  = (NW + 1) / 2 + 1;      // trial divisor width
    localparam int DSW = 2 * HW;                // divisor square width
    localparam int SW  = NW + 4;                // divisor sum width
    localparam int EW  = (SW > SUM_W) ? SW : SUM_W;

    asc_state_t state_reg, state_next;

    logic [NW-1:0]      n_reg, n_next;
    logic               restart_reg, restart_next;
    logic [HW-1:0]      d_reg, d_next;
    logic [DSW-1:0]     dsq_reg, dsq_next;
    logic [SW-1:0]      acc_reg, acc_next;
    logic [TALLY_W-1:0] def_reg, def_next;
    logic [TALLY_W-1:0] abn_reg, abn_next;
    logic [TALLY_W-1:0] prf_reg, prf_next;
    logic               m_valid_reg, m_valid_next;
    asc_out_t           out_reg, out_next;

    logic               div_start;
    logic               div_done;
    logic [NW-1:0]      div_quo;
    logic [NW-1:0]      div_rem;

    logic               s_xfer;
    logic               search_over;
    logic               out_free;
    logic [NW-1:0]      pair;
    logic [SW-1:0]      sum_exact;
    logic [EW-1:0]      sum_ext;
    logic [SUM_W-1:0]   sum_field;
    num_class_t         cls;
    logic [TALLY_W-1:0] def_base, abn_base, prf_base;

    // Shared divider: n / d
    asc_divider #(
        .WIDTH(NW)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (n_reg),
        .divisor  (NW'(d_reg)),
        .done     (div_done),
        .quotient (div_quo),
        .remainder(div_rem)
    );

    assign s_xfer      = s_valid && s_ready;
    assign search_over = (dsq_reg > DSW'(n_reg));
    assign out_free    = !m_valid_reg || m_ready;

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) state_next = ST_TEST;
            end
            ST_TEST: begin
                state_next = search_over ? ST_DONE : ST_DIV;
            end
            ST_DIV: begin
                if (div_done) state_next = ST_ADD;
            end
            ST_ADD: begin
                state_next = ST_TEST;
            end
            ST_DONE: begin
                if (out_free) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Handshake and divider control
    always_comb begin
        s_ready   = (state_reg == ST_IDLE);
        div_start = (state_reg == ST_TEST) && !search_over;
    end

    // Classification of the finished sum
    always_comb begin
        sum_exact = acc_reg - SW'(n_reg);
        sum_ext   = EW'(sum_exact);
        if (n_reg == '0) begin
            sum_field = SUM_NEG_ONE;
            cls       = CLASS_DEFICIENT;
        end else begin
            sum_field = (sum_ext > EW'(SUM_MAX)) ? SUM_MAX : sum_ext[SUM_W-1:0];
            if (sum_exact < SW'(n_reg)) begin
                cls = CLASS_DEFICIENT;
            end else if (sum_exact > SW'(n_reg)) begin
                cls = CLASS_ABUNDANT;
            end else begin
                cls = CLASS_PERFECT;
            end
        end
    end

    // Datapath updates
    always_comb begin
        n_next       = n_reg;
        restart_next = restart_reg;
        d_next       = d_reg;
        dsq_next     = dsq_reg;
        acc_next     = acc_reg;
        def_next     = def_reg;
        abn_next     = abn_reg;
        prf_next     = prf_reg;
        m_valid_next = m_valid_reg;
        out_next     = out_reg;
        pair         = (div_quo != NW'(d_reg)) ? div_quo : '0;
        def_base     = restart_reg ? '0 : def_reg;
        abn_base     = restart_reg ? '0 : abn_reg;
        prf_base     = restart_reg ? '0 : prf_reg;

        if (m_valid_reg && m_ready) m_valid_next = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                if (s_xfer) begin
                    n_next       = NW'(s_payload.value);
                    restart_next = s_payload.restart;
                    d_next       = HW'(1);
                    dsq_next     = DSW'(1);
                    acc_next     = '0;
                end
            end
            ST_ADD: begin
                // divisor pair (d, n/d) when d divides n
                if (div_rem == '0) begin
                    acc_next = acc_reg + SW'(d_reg) + SW'(pair);
                end
                d_next   = d_reg + HW'(1);
                dsq_next = dsq_reg + DSW'({d_reg, 1'b1});
            end
            ST_DONE: begin
                if (out_free) begin
                    def_next = def_base;
                    abn_next = abn_base;
                    prf_next = prf_base;
                    case (cls)
                        CLASS_DEFICIENT: begin
                            if (def_base != TALLY_MAX) def_next = def_base + TALLY_W'(1);
                        end
                        CLASS_ABUNDANT: begin
                            if (abn_base != TALLY_MAX) abn_next = abn_base + TALLY_W'(1);
                        end
                        CLASS_PERFECT: begin
                            if (prf_base != TALLY_MAX) prf_next = prf_base + TALLY_W'(1);
                        end
                        default: begin
                            def_next = def_base;
                        end
                    endcase
                    m_valid_next             = 1'b1;
                    out_next.divisor_sum     = sum_field;
                    out_next.number_class    = cls;
                    out_next.deficient_count = def_next;
                    out_next.abundant_count  = abn_next;
                    out_next.perfect_count   = prf_next;
                end
            end
            default: begin
                n_next = n_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            def_reg     <= '0;
            abn_reg     <= '0;
            prf_reg     <= '0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            def_reg     <= def_next;
            abn_reg     <= abn_next;
            prf_reg     <= prf_next;
        end
        n_reg       <= n_next;
        restart_reg <= restart_next;
        d_reg       <= d_next;
        dsq_reg     <= dsq_next;
        acc_reg     <= acc_next;
        out_reg     <= out_next;
    end

    assign m_valid   = m_valid_reg;
    assign m_payload = out_reg;

endmodule
`default_nettype wire

// ----- tb/aliquot_sum_classifier_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aliquot_sum_classifier_tb: self-checking bench for the aliquot sum classifier
// Feeds numbers over the input channel, predicts the divisor sum, class and
// the three saturating tallies for each transfer, and compares every result
// field with the oldest prediction. Both sides idle at random.
// ----------------------------------------------------------------------------
module aliquot_sum_classifier_tb;
    import asc_pkg::*;

    localparam int VALUE_BITS   = 16;
    localparam int HALF_PERIOD  = 10;
    localparam int RESET_CYCLES = 6;
    localparam int RANDOM_ITEMS = 100;
    localparam int MAX_GAP      = 18;
    localparam int LONG_HOLD    = 6000;  // outlasts the slowest single item
    localparam int HOLD_AT      = 40;    // result count that starts the long hold
    localparam int IDLE_LIMIT   = 50000; // cycles without any transfer
    localparam int SETTLE       = 100;

    // One queued number plus a flag to drain the block before sending it
    typedef struct {
        asc_in_t number;
        bit      drain_first;
    } number_job_t;

    logic     aclk      = 1'b0;
    logic     aresetn   = 1'b0;
    logic     s_valid   = 1'b0;
    logic     s_ready;
    asc_in_t  s_payload = '0;
    logic     m_valid;
    logic     m_ready   = 1'b0;
    asc_out_t m_payload;

    number_job_t job_queue[$];
    asc_out_t    predicted_results[$];

    // Predictor state
    logic [TALLY_W-1:0] deficient_tally;
    logic [TALLY_W-1:0] abundant_tally;
    logic [TALLY_W-1:0] perfect_tally;

    int error_count = 0;
    int result_count = 0;

    // Driver bookkeeping
    int   send_gap   = 0;
    bit   send_burst = 1'b0;
    logic send_next_valid;

    // Monitor bookkeeping
    int   recv_stall   = 0;
    bit   recv_burst   = 1'b0;
    int   hold_left    = 0;
    bit   hold_done    = 1'b0;
    logic recv_next_ready;

    int idle_cycles = 0;

    aliquot_sum_classifier #(
        .VALUE_BITS(VALUE_BITS)
    ) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

    always #HALF_PERIOD aclk = ~aclk;

    // Sum of proper divisors of n >= 1, walking divisor pairs up to sqrt(n)
    function automatic longint unsigned proper_divisor_sum(longint unsigned n);
        longint unsigned total;
        longint unsigned d;
        total = 0;
        for (d = 1; d * d <= n; d++) begin
            if (n % d == 0) begin
                total += d;
                if (n / d != d)
                    total += n / d;
            end
        end
        return total - n;
    endfunction

    function automatic logic [TALLY_W-1:0] bump_tally(logic [TALLY_W-1:0] t);
        return (t == TALLY_MAX) ? t : t + 1'b1;
    endfunction

    // Work out the result for one accepted number and queue it
    function automatic void classify_number(asc_in_t number);
        longint unsigned n;
        longint unsigned total;
        num_class_t      cls;
        asc_out_t        res;
        n = number.value & ((64'd1 << VALUE_BITS) - 1);
        if (number.restart) begin
            deficient_tally = '0;
            abundant_tally  = '0;
            perfect_tally   = '0;
        end
        if (n == 0) begin
            res.divisor_sum = SUM_NEG_ONE;
            cls = CLASS_DEFICIENT;
        end else begin
            total = proper_divisor_sum(n);
            if (total < n)
                cls = CLASS_DEFICIENT;
            else if (total > n)
                cls = CLASS_ABUNDANT;
            else
                cls = CLASS_PERFECT;
            res.divisor_sum = (total > SUM_MAX) ? SUM_MAX : total[SUM_W-1:0];
        end
        case (cls)
            CLASS_DEFICIENT: deficient_tally = bump_tally(deficient_tally);
            CLASS_ABUNDANT:  abundant_tally  = bump_tally(abundant_tally);
            default:         perfect_tally   = bump_tally(perfect_tally);
        endcase
        res.number_class    = cls;
        res.deficient_count = deficient_tally;
        res.abundant_count  = abundant_tally;
        res.perfect_count   = perfect_tally;
        predicted_results.push_back(res);
    endfunction

    function automatic int draw_gap(inout bit burst);
        // flip between idling and back-to-back stretches now and then
        if ($urandom_range(0, 15) == 0)
            burst = !burst;
        return burst ? 0 : $urandom_range(0, MAX_GAP);
    endfunction

    task automatic add_job(input logic [VALUE_W-1:0] value, input logic restart,
                           input bit drain_first);
        number_job_t job;
        job.number.value   = value;
        job.number.restart = restart;
        job.drain_first    = drain_first;
        job_queue.push_back(job);
    endtask

    task automatic check_field(input string label, input logic [31:0] want,
                               input logic [31:0] seen);
        if (seen !== want) begin
            $display("%0t ns: %s expected %0d (0x%h), got %0d (0x%h)",
                     $time, label, want, want, seen, seen);
            error_count++;
        end
    endtask

    // Driver: offers queued numbers, predicts each one on transfer
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid   <= 1'b0;
            s_payload <= '0;
            send_gap  = draw_gap(send_burst);
        end else begin
            send_next_valid = s_valid;
            if (s_valid && s_ready) begin
                classify_number(s_payload);
                send_next_valid = 1'b0;
                send_gap = draw_gap(send_burst);
            end
            if (!send_next_valid) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (job_queue.size() > 0 &&
                             (!job_queue[0].drain_first || predicted_results.size() == 0)) begin
                    s_payload <= job_queue[0].number;
                    void'(job_queue.pop_front());
                    send_next_valid = 1'b1;
                end
            end
            s_valid <= send_next_valid;
        end
    end

    // Monitor: checks each result transfer, stalls at random, one long hold
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready    <= 1'b0;
            recv_stall = draw_gap(recv_burst);
        end else begin
            if (m_valid && m_ready) begin
                if (predicted_results.size() == 0) begin
                    $display("%0t ns: result with none expected, got 0x%h", $time, m_payload);
                    error_count++;
                end else begin
                    check_field("divisor_sum", 32'(predicted_results[0].divisor_sum),
                                32'(m_payload.divisor_sum));
                    check_field("number_class", 32'(predicted_results[0].number_class),
                                32'(m_payload.number_class));
                    check_field("deficient_count", predicted_results[0].deficient_count,
                                m_payload.deficient_count);
                    check_field("abundant_count", predicted_results[0].abundant_count,
                                m_payload.abundant_count);
                    check_field("perfect_count", predicted_results[0].perfect_count,
                                m_payload.perfect_count);
                    void'(predicted_results.pop_front());
                end
                result_count++;
                recv_stall = draw_gap(recv_burst);
            end
            if (hold_left > 0) begin
                hold_left--;
                recv_next_ready = 1'b0;
            end else if (!hold_done && result_count == HOLD_AT) begin
                // long back-pressure so the block fills and blocks its input
                hold_done = 1'b1;
                hold_left = LONG_HOLD;
                recv_next_ready = 1'b0;
            end else if (recv_stall > 0) begin
                recv_stall--;
                recv_next_ready = 1'b0;
            end else begin
                recv_next_ready = 1'b1;
            end
            m_ready <= recv_next_ready;
        end
    end

    // Watchdog on cycles with no transfer on either channel
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("%0t ns: no transfer for %0d cycles", $time, IDLE_LIMIT);
                $display("aliquot_sum_classifier_tb: errors");
                $finish;
            end
        end
    end

    // Stimulus, reset and end of run
    initial begin
        int unsigned pick;
        logic [VALUE_W-1:0] value;
        deficient_tally = '0;
        abundant_tally  = '0;
        perfect_tally   = '0;

        // Directed: zero, one, perfect numbers, abundant and deficient extremes
        add_job(16'd0,     1'b1, 1'b0);  // zero sums to -1, deficient
        add_job(16'd1,     1'b0, 1'b0);  // one has no proper divisors
        add_job(16'd2,     1'b0, 1'b0);
        add_job(16'd6,     1'b0, 1'b0);
        add_job(16'd12,    1'b0, 1'b0);
        add_job(16'd28,    1'b0, 1'b0);
        add_job(16'd496,   1'b0, 1'b0);
        add_job(16'd945,   1'b0, 1'b0);  // smallest odd abundant
        add_job(16'd8128,  1'b0, 1'b0);
        add_job(16'd65535, 1'b0, 1'b0);
        add_job(16'd65534, 1'b0, 1'b0);
        add_job(16'd65520, 1'b0, 1'b0);
        add_job(16'd32768, 1'b0, 1'b0);
        add_job(16'd65521, 1'b0, 1'b0);  // largest 16-bit prime
        add_job(16'h5555,  1'b0, 1'b0);
        add_job(16'hAAAA,  1'b0, 1'b0);
        add_job(16'd0,     1'b0, 1'b0);
        add_job(16'd6,     1'b1, 1'b0);  // restart on a perfect number
        add_job(16'd18,    1'b1, 1'b0);  // restart on an abundant number
        add_job(16'd1,     1'b1, 1'b0);  // restart on one
        add_job(16'd0,     1'b1, 1'b0);

        // Random: mostly small numbers, some full width, some perfect
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 65)
                value = VALUE_W'($urandom_range(0, 1023));
            else if (pick < 75)
                value = VALUE_W'($urandom_range(0, 3));
            else if (pick < 85) begin
                case ($urandom_range(0, 3))
                    0: value = 16'd6;
                    1: value = 16'd28;
                    2: value = 16'd496;
                    default: value = 16'd8128;
                endcase
            end else
                value = VALUE_W'($urandom_range(0, 65535));
            add_job(value, ($urandom_range(0, 11) == 0),
                    (i == 0) || (i == 50) || (i == 80));
        end

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        while (job_queue.size() > 0 || s_valid || predicted_results.size() > 0)
            @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);

        if (error_count == 0)
            $display("aliquot_sum_classifier_tb: clean");
        else
            $display("aliquot_sum_classifier_tb: errors");
        $finish;
    end

endmodule
